FILE: src/ecd_pkg.sv
// Shared types, constants and the month length table for the epoch to
// calendar converter. No dependencies; every other file in src but ecd_intf imports it.

package ecd_pkg;

    localparam logic [31:0] SecsPerDay  = 32'd86400;
    localparam logic [31:0] SecsPerHour = 32'd3600;
    localparam logic [31:0] SecsPerMin  = 32'd60;
    localparam logic [11:0] FirstYear   = 12'd1970;

    // Residues of the first year and their wrap values, used to track the leap rule incrementally.
    localparam logic [1:0]  FirstMod4   = 2'd2;
    localparam logic [6:0]  FirstMod100 = 7'd70;
    localparam logic [8:0]  FirstMod400 = 9'd370;
    localparam logic [6:0]  LastMod100  = 7'd99;
    localparam logic [8:0]  LastMod400  = 9'd399;

    localparam logic [8:0]  DaysLeapYear   = 9'd366;
    localparam logic [8:0]  DaysCommonYear = 9'd365;

    localparam logic [3:0]  MonthJan = 4'd1;
    localparam logic [3:0]  MonthFeb = 4'd2;
    localparam logic [3:0]  MonthDec = 4'd12;

    localparam logic [3:0]  DayBits  = 4'd15;
    localparam logic [3:0]  HourBits = 4'd4;
    localparam logic [3:0]  MinBits  = 4'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAYS,
        ST_HOURS,
        ST_MINS,
        ST_YEARS,
        ST_MONTHS,
        ST_DONE
    } ecd_state_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } ecd_sub_req_t;

    typedef struct packed {
        logic        ge;
        logic [31:0] diff;
    } ecd_sub_rsp_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } ecd_result_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1:     len = 5'd31;
            MonthFeb: len = leap ? 5'd29 : 5'd28;
            4'd3:     len = 5'd31;
            4'd4:     len = 5'd30;
            4'd5:     len = 5'd31;
            4'd6:     len = 5'd30;
            4'd7:     len = 5'd31;
            4'd8:     len = 5'd31;
            4'd9:     len = 5'd30;
            4'd10:    len = 5'd31;
            4'd11:    len = 5'd30;
            4'd12:    len = 5'd31;
            default:  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: src/ecd_intf.sv
// Handshake channels of the converter: the timestamp word in and the
// calendar word out. Depends on nothing.

interface ecd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecd_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, output ready);
endinterface

FILE: src/ecd_sub_unit.sv
// Shared 32-bit compare and subtract unit, used for every division step and
// every year and month subtraction. Depends on ecd_pkg.

module ecd_sub_unit
    import ecd_pkg::*;
(
    input  ecd_sub_req_t req,
    output ecd_sub_rsp_t rsp
);

    logic [32:0] wide_diff;

    assign wide_diff = {1'b0, req.a} - {1'b0, req.b};
    assign rsp.ge    = ~wide_diff[32];
    assign rsp.diff  = wide_diff[31:0];

endmodule

FILE: src/ecd_ctrl.sv
// Sequencer of the converter: restoring division by day, hour and minute,
// then year and month stepping, all through the shared subtract unit.
// Depends on ecd_pkg.

module ecd_ctrl
    import ecd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [31:0]  epoch_seconds,
    output logic         idle,
    output logic         done,
    input  logic         ack,
    output ecd_result_t  result,
    output ecd_sub_req_t sub_req,
    input  ecd_sub_rsp_t sub_rsp
);

    ecd_state_t  state_reg, state_next;
    logic [3:0]  bit_reg;
    logic [31:0] rem_reg;
    logic [15:0] days_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [1:0]  mod4_reg;
    logic [6:0]  mod100_reg;
    logic [8:0]  mod400_reg;
    logic        leap;
    logic        last_bit;
    logic        month_step;

    assign leap       = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));
    assign last_bit   = (bit_reg == 4'd0);
    assign month_step = (month_reg != MonthDec) && sub_rsp.ge;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_DAYS;
            ST_DAYS:   if (last_bit) state_next = ST_HOURS;
            ST_HOURS:  if (last_bit) state_next = ST_MINS;
            ST_MINS:   if (last_bit) state_next = ST_YEARS;
            ST_YEARS:  if (!sub_rsp.ge) state_next = ST_MONTHS;
            ST_MONTHS: if (!month_step) state_next = ST_DONE;
            ST_DONE:   if (ack) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        idle      = 1'b0;
        done      = 1'b0;
        sub_req.a = rem_reg;
        sub_req.b = 32'd0;
        case (state_reg)
            ST_IDLE:   idle = 1'b1;
            ST_DAYS:   sub_req.b = SecsPerDay << bit_reg;
            ST_HOURS:  sub_req.b = SecsPerHour << bit_reg;
            ST_MINS:   sub_req.b = SecsPerMin << bit_reg;
            ST_YEARS:
            begin
                sub_req.a = {16'd0, days_reg};
                sub_req.b = {23'd0, leap ? DaysLeapYear : DaysCommonYear};
            end
            ST_MONTHS:
            begin
                sub_req.a = {16'd0, days_reg};
                sub_req.b = {27'd0, month_len(month_reg, leap)};
            end
            ST_DONE:   done = 1'b1;
            default:   idle = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers; each step either keeps or takes the unit's difference.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_reg    <= epoch_seconds;
                    days_reg   <= 16'd0;
                    bit_reg    <= DayBits;
                    year_reg   <= FirstYear;
                    month_reg  <= MonthJan;
                    mod4_reg   <= FirstMod4;
                    mod100_reg <= FirstMod100;
                    mod400_reg <= FirstMod400;
                end
            end
            ST_DAYS:
            begin
                if (sub_rsp.ge) rem_reg <= sub_rsp.diff;
                days_reg <= {days_reg[14:0], sub_rsp.ge};
                bit_reg  <= last_bit ? HourBits : bit_reg - 4'd1;
            end
            ST_HOURS:
            begin
                if (sub_rsp.ge) rem_reg <= sub_rsp.diff;
                hour_reg <= {hour_reg[3:0], sub_rsp.ge};
                bit_reg  <= last_bit ? MinBits : bit_reg - 4'd1;
            end
            ST_MINS:
            begin
                if (sub_rsp.ge) rem_reg <= sub_rsp.diff;
                minute_reg <= {minute_reg[4:0], sub_rsp.ge};
                bit_reg    <= bit_reg - 4'd1;
            end
            ST_YEARS:
            begin
                if (sub_rsp.ge)
                begin
                    days_reg   <= sub_rsp.diff[15:0];
                    year_reg   <= year_reg + 12'd1;
                    mod4_reg   <= mod4_reg + 2'd1;
                    mod100_reg <= (mod100_reg == LastMod100) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_reg <= (mod400_reg == LastMod400) ? 9'd0 : mod400_reg + 9'd1;
                end
            end
            ST_MONTHS:
            begin
                if (month_step)
                begin
                    days_reg  <= sub_rsp.diff[15:0];
                    month_reg <= month_reg + 4'd1;
                end
            end
            default:
            begin
                bit_reg <= bit_reg;
            end
        endcase
    end

    assign result.year         = year_reg;
    assign result.month        = month_reg;
    assign result.day_of_month = days_reg[4:0] + 5'd1;
    assign result.hour         = hour_reg;
    assign result.minute       = minute_reg;
    assign result.second       = rem_reg[5:0];

    a_start_enters_days: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> (state_reg == ST_DAYS))
        else $error("accepted word did not start the day division");

    a_days_to_hours: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DAYS && last_bit) |=> (state_reg == ST_HOURS && bit_reg == HourBits))
        else $error("day division did not hand over to the hour division");

    a_done_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (month_reg >= MonthJan && month_reg <= MonthDec))
        else $error("month out of range at completion");

    a_done_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (year_reg >= FirstYear && year_reg <= 12'd2106
                                    && days_reg < 16'd31 && rem_reg < 32'd60))
        else $error("year, day or second out of range at completion");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !ack) |=> (state_reg == ST_DONE && $stable(days_reg)))
        else $error("finished result left before it was taken");

endmodule

FILE: src/epoch_seconds_to_calendar_date.sv
// Top level of the epoch seconds to Gregorian date converter: the sequencer,
// the shared subtract unit and the output register. Depends on ecd_pkg,
// ecd_intf, ecd_sub_unit and ecd_ctrl.
//
//   Channel  Direction  Word
//   stamp    in         epoch_seconds (32 bits)
//   date     out        year, month, day_of_month, hour, minute, second
//
// Every division bit and every year and month step of a word is done by the
// single shared subtractor, so the sequencer takes one word at a time.
// Reset clears the sequencer and the output valid flag; the datapath and output registers are not reset.
// A finished result moves into the output register as soon as it is free, so a
// stalled output holds back the next word only once that word is finished too.

module epoch_seconds_to_calendar_date
    import ecd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ecd_in_if.sink   stamp,
    ecd_out_if.source date
);

    ecd_sub_req_t sub_req;
    ecd_sub_rsp_t sub_rsp;
    ecd_result_t  result;
    ecd_result_t  out_reg;
    logic         out_valid_reg;
    logic         idle;
    logic         done;
    logic         load;
    logic         start;

    assign stamp.ready = idle;
    assign start       = stamp.valid && idle;
    assign load        = done && (!out_valid_reg || date.ready);

    ecd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .epoch_seconds (stamp.epoch_seconds),
        .idle          (idle),
        .done          (done),
        .ack           (load),
        .result        (result),
        .sub_req       (sub_req),
        .sub_rsp       (sub_rsp)
    );

    ecd_sub_unit u_sub (
        .req (sub_req),
        .rsp (sub_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (date.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= result;
        end
    end

    assign date.valid        = out_valid_reg;
    assign date.year         = out_reg.year;
    assign date.month        = out_reg.month;
    assign date.day_of_month = out_reg.day_of_month;
    assign date.hour         = out_reg.hour;
    assign date.minute       = out_reg.minute;
    assign date.second       = out_reg.second;

endmodule
